### sv/altab_pkg.sv
// altab_pkg: shared types and constants for the array list table engine
// holds field widths, default capacity, request action codes, status codes and sequencer states
// no dependencies
package altab_pkg;

	// field widths fixed by the request and result formats
	localparam int DATA_W    = 32;
	localparam int POS_W     = 7;
	localparam int CNT_OUT_W = 8;

	// default list capacity
	localparam int DEFAULT_CAPACITY = 128;

	// request actions
	typedef enum logic [1:0] {
		ACT_FIND    = 2'd0,
		ACT_REPLACE = 2'd1,
		ACT_APPEND  = 2'd2,
		ACT_REMOVE  = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_BOUNDS    = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_REPL,
		S_DONE
	} state_t;

endpackage

### sv/array_list_table_engine.sv
// array_list_table_engine: packed list of signed 32-bit values with linear search
// single module with list memory, scan sequencer and one shared compare unit
// depends on altab_pkg
//
// Usage:
// A request is taken at a rising edge where start is high and busy is low;
// action, position and item_value are sampled then. busy stays high until the
// result has been shown. The result (status, found_position, previous_value,
// count_after) is valid for exactly one cycle while done is high; the receiver
// cannot hold it off, and busy falls in the cycle after done.
// Steps from the accepting edge to the done cycle:
//   append, and any request that fails its index or capacity check: decide, then done
//   replace: decide with one memory read, then the write, then done
//   find, remove: decide, then a scan that ends in done; the
//   list memory has a single read port, so the scan reads one entry per cycle
//   while the compare (find) or the write one place down (remove) handles the
//   entry read the cycle before
// A new request can be taken in the cycle after done.
// Reset clears the fill count and the sequencer; list memory contents are
// not cleared, since entries at or above the fill count are never read.
module array_list_table_engine #(
	parameter int CAPACITY = altab_pkg::DEFAULT_CAPACITY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           action,
	input  logic [altab_pkg::POS_W-1:0]          position,
	input  logic signed [altab_pkg::DATA_W-1:0]  item_value,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [altab_pkg::POS_W-1:0]          found_position,
	output logic signed [altab_pkg::DATA_W-1:0]  previous_value,
	output logic [altab_pkg::CNT_OUT_W-1:0]      count_after
);

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > altab_pkg::POS_W) ? CW : altab_pkg::POS_W;
	localparam int OW   = (CW > altab_pkg::CNT_OUT_W) ? CW : altab_pkg::CNT_OUT_W;
	localparam int DW   = altab_pkg::DATA_W;

	altab_pkg::state_t  state_q, state_d;
	altab_pkg::action_t act_q;
	altab_pkg::status_t status_q;

	logic [altab_pkg::POS_W-1:0] pos_q;
	logic [DW-1:0]               val_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               rd_idx_q;
	logic [AW-1:0]               chk_idx_q;
	logic                        chk_vld_q;
	logic [altab_pkg::POS_W-1:0] found_q;
	logic [DW-1:0]               prev_q;
	logic [DW-1:0]               rdata_q;

	// list storage
	logic [DW-1:0] mem [CAPACITY];

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [DW-1:0] wr_data;

	logic [CMPW-1:0] pos_ext, cnt_ext, chk_idx_ext;
	logic [OW-1:0]   cnt_out;
	logic            pos_ok, full, issue, hit, scan_end;

	// widened views for compares and output masking
	assign pos_ext     = CMPW'(pos_q);
	assign cnt_ext     = CMPW'(count_q);
	assign chk_idx_ext = CMPW'(chk_idx_q);
	assign cnt_out     = OW'(count_q);

	// shared compare unit and scan control
	assign pos_ok   = pos_ext < cnt_ext;
	assign full     = count_q >= CW'(CAPACITY);
	assign issue    = rd_idx_q < count_q;
	assign hit      = chk_vld_q && (rdata_q == val_q);
	assign scan_end = !chk_vld_q && !issue;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			altab_pkg::S_IDLE: begin
				if (start) begin
					state_d = altab_pkg::S_DECIDE;
				end
			end
			altab_pkg::S_DECIDE: begin
				priority if ((act_q == altab_pkg::ACT_FIND) ||
					((act_q == altab_pkg::ACT_REMOVE) && pos_ok)) begin
					state_d = altab_pkg::S_SCAN;
				end else if ((act_q == altab_pkg::ACT_REPLACE) && pos_ok) begin
					state_d = altab_pkg::S_REPL;
				end else begin
					state_d = altab_pkg::S_DONE;
				end
			end
			altab_pkg::S_SCAN: begin
				if (((act_q == altab_pkg::ACT_FIND) && hit) || scan_end) begin
					state_d = altab_pkg::S_DONE;
				end
			end
			altab_pkg::S_REPL: state_d = altab_pkg::S_DONE;
			altab_pkg::S_DONE: state_d = altab_pkg::S_IDLE;
			default:           state_d = altab_pkg::S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_idx_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = val_q;
		unique case (state_q)
			altab_pkg::S_DECIDE: begin
				if (act_q == altab_pkg::ACT_REPLACE && pos_ok) begin
					rd_en   = 1'b1;
					rd_addr = pos_ext[AW-1:0];
				end
				if (act_q == altab_pkg::ACT_APPEND && !full) begin
					wr_en = 1'b1;
				end
			end
			altab_pkg::S_SCAN: begin
				rd_en = issue;
				// remove: move the entry read last cycle one place down
				if (act_q == altab_pkg::ACT_REMOVE && chk_vld_q) begin
					wr_en   = 1'b1;
					wr_addr = chk_idx_q - AW'(1);
					wr_data = rdata_q;
				end
			end
			altab_pkg::S_REPL: begin
				wr_en   = 1'b1;
				wr_addr = pos_ext[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// list memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= altab_pkg::S_IDLE;
			count_q   <= '0;
			chk_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				altab_pkg::S_DECIDE: begin
					chk_vld_q <= 1'b0;
					if (act_q == altab_pkg::ACT_APPEND && !full) begin
						count_q <= count_q + CW'(1);
					end
				end
				altab_pkg::S_SCAN: begin
					chk_vld_q <= issue;
					if (scan_end && act_q == altab_pkg::ACT_REMOVE) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					chk_vld_q <= 1'b0;
				end
			endcase
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			altab_pkg::S_IDLE: begin
				if (start) begin
					act_q <= altab_pkg::action_t'(action);
					pos_q <= position;
					val_q <= item_value;
				end
			end
			altab_pkg::S_DECIDE: begin
				status_q <= altab_pkg::ST_OK;
				found_q  <= '0;
				prev_q   <= '0;
				rd_idx_q <= '0;
				if ((act_q == altab_pkg::ACT_REPLACE || act_q == altab_pkg::ACT_REMOVE)
					&& !pos_ok) begin
					status_q <= altab_pkg::ST_BOUNDS;
				end
				if (act_q == altab_pkg::ACT_APPEND && full) begin
					status_q <= altab_pkg::ST_FULL;
				end
				if (act_q == altab_pkg::ACT_REMOVE) begin
					rd_idx_q <= CW'(pos_ext + CMPW'(1));
				end
			end
			altab_pkg::S_SCAN: begin
				if (issue) begin
					rd_idx_q  <= rd_idx_q + CW'(1);
					chk_idx_q <= rd_idx_q[AW-1:0];
				end
				if (act_q == altab_pkg::ACT_FIND && hit) begin
					found_q <= chk_idx_ext[altab_pkg::POS_W-1:0];
				end
				if (act_q == altab_pkg::ACT_FIND && scan_end) begin
					status_q <= altab_pkg::ST_NOT_FOUND;
				end
			end
			altab_pkg::S_REPL: begin
				prev_q <= rdata_q;
			end
			default: begin
				found_q <= found_q;
			end
		endcase
	end

	// result ports
	assign busy           = (state_q != altab_pkg::S_IDLE);
	assign done           = (state_q == altab_pkg::S_DONE);
	assign status         = status_q;
	assign found_position = found_q;
	assign previous_value = prev_q;
	assign count_after    = cnt_out[altab_pkg::CNT_OUT_W-1:0];

	// fill count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	// an accepted request raises busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// the result cycle returns the block to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after result");

	// full status only when the list is at capacity
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q == altab_pkg::ST_FULL) |-> (count_q == CW'(CAPACITY)))
		else $error("full reported below capacity");

endmodule
